// ----- rtl/nspq_pkg.sv -----
`timescale 1ns / 1ps

package nspq_pkg;

   localparam int ID_W     = 16;
   localparam int PTS_W    = 16;
   localparam int ENTRY_W  = ID_W + PTS_W;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PAIR   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  member_id;
      logic [PTS_W-1:0] player_points;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     first_id;
      logic [ID_W-1:0]     second_id;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

endpackage

// ----- rtl/nspq_ifs.sv -----
`timescale 1ns / 1ps

interface nspq_req_if;
   logic              valid;
   logic              ready;
   nspq_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface nspq_rsp_if;
   logic              valid;
   logic              ready;
   nspq_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/nspq_ram.sv -----
`timescale 1ns / 1ps

module nspq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/nearest_score_pairing_queue.sv -----
`timescale 1ns / 1ps

// Ordered waiting list of up to DEPTH (id, score) entries kept in one
// single-port-read RAM. One transaction is taken at a time; req_ch.ready is
// low while a command runs. Insert writes the entry, if there is room, as it
// is accepted. Remove scans the list, then, on a hit at position p, shifts the
// tail down over p. Pair scans the whole list and then rewrites it from the
// head, skipping the head and the chosen partner. Scan and compaction both run
// on the one RAM read port, which delivers one entry per cycle to the scan
// compares and to the compaction pass; the difference unit serves the pair scan.
// A finished response waits in an output register, so the next transaction
// is taken while the response is still pending. No clearing pass after
// reset: only positions below the occupancy are ever read.

module nearest_score_pairing_queue #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   nspq_req_if.sink    req_ch,
   nspq_rsp_if.source  rsp_ch
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMPACT,
      S_FINISH
   } state_type;

   // sequencer state
   state_type               state_ff, state_in;
   logic [CW-1:0]           occ_ff, occ_in;
   logic [nspq_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [nspq_pkg::ID_W-1:0]  pid_ff, pid_in;

   // read issue counter and returned-data stage
   logic [CW-1:0]           rd_ff, rd_in;
   logic                    dv_ff, dv_in;
   logic [AW-1:0]           didx_ff, didx_in;

   // compaction pointers
   logic [AW-1:0]           wr_ff, wr_in;
   logic [AW-1:0]           skip_a_ff, skip_a_in;
   logic [AW-1:0]           skip_b_ff, skip_b_in;

   // search results
   logic                    found_ff, found_in;
   logic [AW-1:0]           best_ff, best_in;
   logic [nspq_pkg::PTS_W:0]   best_diff_ff, best_diff_in;
   logic [nspq_pkg::PTS_W-1:0] head_pts_ff, head_pts_in;
   logic [nspq_pkg::ID_W-1:0]  head_id_ff, head_id_in;
   logic [nspq_pkg::ID_W-1:0]  first_ff, first_in;
   logic [nspq_pkg::ID_W-1:0]  second_ff, second_in;
   logic [nspq_pkg::STATUS_W-1:0] status_ff, status_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   nspq_pkg::rsp_type       rsp_ff, rsp_in;

   // RAM ports
   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [nspq_pkg::ENTRY_W-1:0]  ram_wdata;
   logic [AW-1:0]                 ram_raddr;
   logic [nspq_pkg::ENTRY_W-1:0]  ram_rdata;

   logic [nspq_pkg::ID_W-1:0]     rd_id;
   logic [nspq_pkg::PTS_W-1:0]    rd_pts;

   // difference / compare unit for the pair scan
   logic [nspq_pkg::PTS_W:0]      sub;
   logic [nspq_pkg::PTS_W:0]      diff;
   logic                          closer;

   logic accept;
   logic issuing;

   nspq_ram #(
      .WIDTH (nspq_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign accept         = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   assign rd_id  = ram_rdata[nspq_pkg::ENTRY_W-1:nspq_pkg::PTS_W];
   assign rd_pts = ram_rdata[nspq_pkg::PTS_W-1:0];

   assign sub    = {1'b0, rd_pts} - {1'b0, head_pts_ff};
   assign diff   = sub[nspq_pkg::PTS_W] ? ({1'b0, head_pts_ff} - {1'b0, rd_pts}) : sub;
   assign closer = (diff < best_diff_ff);

   // one read per cycle while below the occupancy, in scan and compaction
   assign issuing   = ((state_ff == S_SCAN) || (state_ff == S_COMPACT)) && (rd_ff < occ_ff);
   assign ram_raddr = rd_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      cmd_in       = cmd_ff;
      pid_in       = pid_ff;
      rd_in        = rd_ff;
      dv_in        = issuing;
      didx_in      = rd_ff[AW-1:0];
      wr_in        = wr_ff;
      skip_a_in    = skip_a_ff;
      skip_b_in    = skip_b_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_diff_in = best_diff_ff;
      head_pts_in  = head_pts_ff;
      head_id_in   = head_id_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = wr_ff;
      ram_wdata    = ram_rdata;

      if (issuing) begin
         rd_in = rd_ff + CW'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_ch.payload.cmd;
               pid_in    = req_ch.payload.member_id;
               first_in  = '0;
               second_in = '0;
               rd_in     = '0;
               found_in  = 1'b0;
               priority if (req_ch.payload.cmd == nspq_pkg::CMD_INSERT) begin
                  state_in = S_FINISH;
                  if (occ_ff == DEPTH_C) begin
                     status_in = nspq_pkg::ST_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = occ_ff[AW-1:0];
                     ram_wdata = {req_ch.payload.member_id, req_ch.payload.player_points};
                     occ_in    = occ_ff + CW'(1);
                     status_in = nspq_pkg::ST_DONE;
                  end
               end else if (req_ch.payload.cmd == nspq_pkg::CMD_REMOVE) begin
                  state_in = S_SCAN;
               end else if (req_ch.payload.cmd == nspq_pkg::CMD_PAIR) begin
                  if (occ_ff < CW'(2)) begin
                     status_in = nspq_pkg::ST_MISS;
                     state_in  = S_FINISH;
                  end else begin
                     best_diff_in = {1'b1, {nspq_pkg::PTS_W{1'b0}}};
                     state_in     = S_SCAN;
                  end
               end else begin
                  status_in = nspq_pkg::ST_MISS;
                  state_in  = S_FINISH;
               end
            end
         end

         S_SCAN: begin
            if (dv_ff) begin
               if (cmd_ff == nspq_pkg::CMD_REMOVE) begin
                  if (!found_ff && (rd_id == pid_ff)) begin
                     found_in = 1'b1;
                     best_in  = didx_ff;
                  end
               end else if (didx_ff == '0) begin
                  head_pts_in = rd_pts;
                  head_id_in  = rd_id;
               end else if (closer) begin
                  best_diff_in = diff;
                  best_in      = didx_ff;
                  second_in    = rd_id;
               end
            end
            if (!issuing && !dv_ff) begin
               if (cmd_ff == nspq_pkg::CMD_REMOVE) begin
                  if (found_ff) begin
                     skip_a_in = best_ff;
                     skip_b_in = best_ff;
                     wr_in     = best_ff;
                     rd_in     = CW'(best_ff);
                     state_in  = S_COMPACT;
                  end else begin
                     status_in = nspq_pkg::ST_MISS;
                     state_in  = S_FINISH;
                  end
               end else begin
                  // drop the head and the partner in a single pass
                  skip_a_in = '0;
                  skip_b_in = best_ff;
                  wr_in     = '0;
                  rd_in     = '0;
                  first_in  = head_id_ff;
                  state_in  = S_COMPACT;
               end
            end
         end

         S_COMPACT: begin
            if (dv_ff && (didx_ff != skip_a_ff) && (didx_ff != skip_b_ff)) begin
               ram_we    = 1'b1;
               ram_waddr = wr_ff;
               ram_wdata = ram_rdata;
               wr_in     = wr_ff + AW'(1);
            end
            if (!issuing && !dv_ff) begin
               occ_in    = (cmd_ff == nspq_pkg::CMD_PAIR) ? (occ_ff - CW'(2))
                                                          : (occ_ff - CW'(1));
               status_in = nspq_pkg::ST_DONE;
               state_in  = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = status_ff;
               rsp_in.first_id  = first_ff;
               rsp_in.second_id = second_ff;
               rsp_in.count     = nspq_pkg::COUNT_W'(occ_ff);
               state_in         = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      pid_ff       <= pid_in;
      rd_ff        <= rd_in;
      didx_ff      <= didx_in;
      wr_ff        <= wr_in;
      skip_a_ff    <= skip_a_in;
      skip_b_ff    <= skip_b_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_diff_ff <= best_diff_in;
      head_pts_ff  <= head_pts_in;
      head_id_ff   <= head_id_in;
      first_ff     <= first_in;
      second_ff    <= second_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

   // occupancy stays within the list
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_C)
      else $error("occupancy above DEPTH");

   // the RAM is written only on insert or during compaction
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_IDLE) || (state_ff == S_COMPACT))
      else $error("RAM write outside insert or compaction");

   // compaction always writes below the entry it just read
   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (ram_we && (state_ff == S_COMPACT)) |-> (wr_ff < didx_ff))
      else $error("compaction write pointer not behind read");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("ready high right after accept");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH        = 64;
   localparam int N_RANDOM     = 1350;
   localparam int LONG_HOLD    = 600;   // receiver hold-off, in cycles
   localparam int HOLD_AT_RSP  = 300;   // response count that triggers the hold-off
   localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
   localparam int REPORT_MAX   = 10;

   // command code with no defined meaning
   localparam logic [nspq_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   // random traffic mixes
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   // Mirror of the waiting list. Each accepted command updates the copy and
   // queues the response the block should send back; responses are matched
   // in order.
   class waitlist_mirror;
      logic [nspq_pkg::ID_W-1:0]  ids    [DEPTH];
      logic [nspq_pkg::PTS_W-1:0] scores [DEPTH];
      int                         occ;
      nspq_pkg::rsp_type          pending_rsp [$];
      int                         failures;

      function new();
         occ      = 0;
         failures = 0;
      endfunction

      // delete one entry and close the gap, order of the rest kept
      function void drop_at(int pos);
         for (int i = pos; i + 1 < occ; i++) begin
            ids[i]    = ids[i + 1];
            scores[i] = scores[i + 1];
         end
         occ--;
      endfunction

      function void take_command(nspq_pkg::req_type cmd_in);
         nspq_pkg::rsp_type exp_rsp;
         bit         found;
         int         pos;
         int         best;
         int         best_diff;
         int         diff;
         exp_rsp.status    = nspq_pkg::ST_MISS;
         exp_rsp.first_id  = '0;
         exp_rsp.second_id = '0;
         case (cmd_in.cmd)
            nspq_pkg::CMD_INSERT: begin
               if (occ >= DEPTH) begin
                  exp_rsp.status = nspq_pkg::ST_FULL;
               end else begin
                  ids[occ]    = cmd_in.member_id;
                  scores[occ] = cmd_in.player_points;
                  occ++;
                  exp_rsp.status = nspq_pkg::ST_DONE;
               end
            end
            nspq_pkg::CMD_REMOVE: begin
               // only the earliest match leaves
               found = 1'b0;
               pos   = 0;
               while (!found && pos < occ) begin
                  if (ids[pos] == cmd_in.member_id) begin
                     found = 1'b1;
                     drop_at(pos);
                     exp_rsp.status = nspq_pkg::ST_DONE;
                  end
                  pos++;
               end
            end
            nspq_pkg::CMD_PAIR: begin
               if (occ >= 2) begin
                  best      = 1;
                  best_diff = 32'h1_0000;
                  for (int i = 1; i < occ; i++) begin
                     diff = (scores[i] >= scores[0]) ? int'(scores[i]) - int'(scores[0])
                                                     : int'(scores[0]) - int'(scores[i]);
                     // strict compare: earliest entry wins a tie
                     if (diff < best_diff) begin
                        best_diff = diff;
                        best      = i;
                     end
                  end
                  exp_rsp.first_id  = ids[0];
                  exp_rsp.second_id = ids[best];
                  drop_at(best);
                  drop_at(0);
                  exp_rsp.status = nspq_pkg::ST_DONE;
               end
            end
            default: begin
               // unknown command: no change, miss status
            end
         endcase
         exp_rsp.count = occ[nspq_pkg::COUNT_W-1:0];
         pending_rsp.insert(pending_rsp.size(), exp_rsp);
      endfunction

      function void match_response(nspq_pkg::rsp_type got);
         nspq_pkg::rsp_type exp_rsp;
         if (pending_rsp.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("%0t: response with none expected: status=%0d first=%h second=%h count=%0d",
                        $realtime, got.status, got.first_id, got.second_id, got.count);
            return;
         end
         exp_rsp = pending_rsp.pop_front();
         if (got.status !== exp_rsp.status || got.first_id !== exp_rsp.first_id ||
             got.second_id !== exp_rsp.second_id || got.count !== exp_rsp.count) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("%0t: mismatch expected status=%0d first=%h second=%h count=%0d",
                        $realtime, exp_rsp.status, exp_rsp.first_id, exp_rsp.second_id,
                        exp_rsp.count);
               $display("%0t:          actual   status=%0d first=%h second=%h count=%0d",
                        $realtime, got.status, got.first_id, got.second_id, got.count);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   nspq_req_if req_bus ();
   nspq_rsp_if rsp_bus ();

   nearest_score_pairing_queue #(
      .DEPTH (DEPTH)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   waitlist_mirror mirror = new();

   bit burst_tx;   // no sender gaps while set

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Idle length: mostly zero or short, now and then a long one.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Identifier: small pool for duplicates, extremes, or fully random.
   function automatic logic [nspq_pkg::ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return nspq_pkg::ID_W'($urandom_range(0, 15));
      if (r < 6) return ($urandom_range(0, 1) != 0) ? {nspq_pkg::ID_W{1'b1}}
                                                    : {nspq_pkg::ID_W{1'b0}};
      return nspq_pkg::ID_W'($urandom());
   endfunction

   // Score: narrow range to provoke ties, extremes, or fully random.
   function automatic logic [nspq_pkg::PTS_W-1:0] pick_score();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return nspq_pkg::PTS_W'($urandom_range(0, 31));
      if (r < 5) begin
         case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return 16'h7FFF;
         endcase
      end
      return nspq_pkg::PTS_W'($urandom());
   endfunction

   // Offer one command and hold it until the block takes it.
   // valid stays high across back-to-back transactions.
   task automatic offer(input logic [nspq_pkg::CMD_W-1:0] cmd,
                        input logic [nspq_pkg::ID_W-1:0] pid,
                        input logic [nspq_pkg::PTS_W-1:0] pts);
      nspq_pkg::req_type item;
      int      gap;
      item.cmd           = cmd;
      item.member_id     = pid;
      item.player_points = pts;
      gap = burst_tx ? 0 : idle_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= item;
      do @(posedge clock); while (!req_bus.ready);
      mirror.take_command(item);
   endtask

   // One random command under the given mix. Removes mostly target an id
   // that is actually waiting so the hit path and the compaction get work.
   task automatic offer_random(input mix_type mix);
      int                         r;
      int                         p_ins;
      int                         p_rem;
      int                         p_pair;
      logic [nspq_pkg::ID_W-1:0]  pid;
      case (mix)
         MIX_FILL:  begin p_ins = 85; p_rem = 92; p_pair = 98; end
         MIX_DRAIN: begin p_ins = 20; p_rem = 55; p_pair = 98; end
         default:   begin p_ins = 50; p_rem = 72; p_pair = 98; end
      endcase
      r = $urandom_range(0, 99);
      if (r < p_ins) begin
         offer(nspq_pkg::CMD_INSERT, pick_id(), pick_score());
      end else if (r < p_rem) begin
         if (mirror.occ > 0 && $urandom_range(0, 3) != 0)
            pid = mirror.ids[$urandom_range(0, mirror.occ - 1)];
         else
            pid = pick_id();
         offer(nspq_pkg::CMD_REMOVE, pid, nspq_pkg::PTS_W'($urandom()));
      end else if (r < p_pair) begin
         offer(nspq_pkg::CMD_PAIR, nspq_pkg::ID_W'($urandom()),
               nspq_pkg::PTS_W'($urandom()));
      end else begin
         offer(CMD_UNKNOWN, nspq_pkg::ID_W'($urandom()), nspq_pkg::PTS_W'($urandom()));
      end
   endtask

   // Receiver: random ready gaps, bursts with ready held high, and one long
   // hold-off so the output register and the input side back up.
   initial begin
      int gap;
      int taken;
      bit hold_done;
      bit burst_rx;
      taken     = 0;
      hold_done = 1'b0;
      burst_rx  = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 100 == 0)
            burst_rx = ($urandom_range(0, 3) == 0);
         if (!hold_done && taken == HOLD_AT_RSP) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         gap = burst_rx ? 0 : idle_cycles();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         mirror.match_response(rsp_bus.payload);
         taken++;
      end
   end

   // Stimulus and end of run.
   initial begin
      int      sent;
      int      len;
      mix_type mix;
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      reset           <= 1'b1;
      burst_tx = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-list cases and unknown command
      offer(nspq_pkg::CMD_PAIR,   16'h0000, 16'h0000);
      offer(nspq_pkg::CMD_REMOVE, 16'h0000, 16'h0000);
      offer(CMD_UNKNOWN,          16'hFFFF, 16'hFFFF);
      // single entry: pair finds no partner, the entry stays
      offer(nspq_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF);
      offer(nspq_pkg::CMD_PAIR,   16'h0000, 16'h0000);
      offer(nspq_pkg::CMD_INSERT, 16'h0000, 16'h0000);
      offer(nspq_pkg::CMD_INSERT, 16'h1234, 16'h8000);
      offer(nspq_pkg::CMD_INSERT, 16'hFFFF, 16'h0000);   // duplicate id
      offer(nspq_pkg::CMD_INSERT, 16'h0007, 16'h0000);
      offer(nspq_pkg::CMD_REMOVE, 16'hFFFF, 16'h0000);   // earliest duplicate = head
      offer(nspq_pkg::CMD_REMOVE, 16'hABCD, 16'h0000);   // no match
      offer(nspq_pkg::CMD_PAIR,   16'h0000, 16'h0000);   // tie at zero distance
      offer(nspq_pkg::CMD_PAIR,   16'h0000, 16'h0000);
      offer(nspq_pkg::CMD_PAIR,   16'h0000, 16'h0000);   // empty again
      // equal distance above and below the head: earlier wins
      offer(nspq_pkg::CMD_INSERT, 16'd100, 16'd500);
      offer(nspq_pkg::CMD_INSERT, 16'd101, 16'd400);
      offer(nspq_pkg::CMD_INSERT, 16'd102, 16'd600);
      offer(nspq_pkg::CMD_PAIR,   16'h0000, 16'h0000);
      // duplicate ids: remove takes only the first
      offer(nspq_pkg::CMD_INSERT, 16'd9,  16'd10);
      offer(nspq_pkg::CMD_INSERT, 16'd9,  16'd20);
      offer(nspq_pkg::CMD_INSERT, 16'd10, 16'd20);
      offer(nspq_pkg::CMD_REMOVE, 16'd9,  16'd0);
      offer(nspq_pkg::CMD_PAIR,   16'h0000, 16'h0000);
      offer(nspq_pkg::CMD_PAIR,   16'h0000, 16'h0000);
      offer(CMD_UNKNOWN,          16'h0000, 16'h0000);

      // random phases: fill runs reach a full list, drain runs empty it
      sent = 0;
      while (sent < N_RANDOM) begin
         mix      = mix_type'($urandom_range(0, 2));
         len      = $urandom_range(20, 120);
         burst_tx = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < len && sent < N_RANDOM; k++) begin
            offer_random(mix);
            sent++;
         end
      end
      req_bus.valid <= 1'b0;

      while (mirror.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/nspq_pkg.sv
rtl/nspq_ifs.sv
rtl/nspq_ram.sv
rtl/nearest_score_pairing_queue.sv
sim/tb.sv
